@@ sv/mbf_pkg.sv @@
package mbf_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int VERTEX_BITS = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int KEY_BITS    = 3 * VERTEX_BITS;
   localparam int USE_BITS    = 2;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_FETCH  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef logic [VERTEX_BITS-1:0] vtx_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] vert0;
      logic [15:0] vert1;
      logic [15:0] vert2;
      logic [15:0] vert3;
   } req_type;

   typedef struct packed {
      logic [15:0] face_a;
      logic [15:0] face_b;
      logic [15:0] face_c;
      logic        face_valid;
      logic        last_face;
      logic        table_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ICHK,
      ST_ICMP,
      ST_FCHK,
      ST_FCMP,
      ST_LCHK,
      ST_LCMP,
      ST_OUT
   } state_type;

   // local vertex picks: tetrahedron faces, then triangle edges
   function automatic logic [1:0] tri_pick(input logic [1:0] face, input logic [1:0] pos);
      logic [1:0] r;
      r = 2'd0;
      unique case (face)
         2'd0: r = (pos == 2'd0) ? 2'd2 : (pos == 2'd1) ? 2'd1 : 2'd0;
         2'd1: r = (pos == 2'd0) ? 2'd0 : (pos == 2'd1) ? 2'd1 : 2'd3;
         2'd2: r = (pos == 2'd0) ? 2'd1 : (pos == 2'd1) ? 2'd2 : 2'd3;
         default: r = (pos == 2'd0) ? 2'd2 : (pos == 2'd1) ? 2'd0 : 2'd3;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] edge_pick(input logic [1:0] face, input logic pos);
      logic [1:0] r;
      r = 2'd0;
      unique case (face)
         2'd0: r = pos ? 2'd0 : 2'd1;
         2'd1: r = pos ? 2'd1 : 2'd2;
         default: r = pos ? 2'd2 : 2'd0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/mbf_req_if.sv @@
interface mbf_req_if;
   logic             valid;
   logic             ready;
   mbf_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/mbf_rsp_if.sv @@
interface mbf_rsp_if;
   logic             valid;
   logic             ready;
   mbf_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/mbf_ram.sv @@
module mbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/mesh_boundary_face_extractor_unit.sv @@
// insert: for each face, a linear key search through the key memory, entry by entry,
//    3 or 4 faces per request
// fetch: the scan runs over the use-count memory
// clear and unused modes: handled in idle; one request in flight, result held in an output register
// reset: synchronous, clears entry total, fetch pointer, overflow flag and
//    sets tetrahedron mode; table memories are not cleared
module mesh_boundary_face_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   mbf_req_if.sink     req_ch,
   mbf_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int IB = mbf_pkg::IDX_BITS;
   localparam int CB = mbf_pkg::CNT_BITS;
   localparam int VB = mbf_pkg::VERTEX_BITS;
   localparam int KB = mbf_pkg::KEY_BITS;
   localparam int UB = mbf_pkg::USE_BITS;
   localparam logic [CB-1:0] FULL = CB'(mbf_pkg::TABLE_DEPTH);

   mbf_pkg::state_type state_ff, state_in;
   logic              tetra_ff, tetra_in;
   logic [CB-1:0]     total_ff, total_in;
   logic [CB-1:0]     fptr_ff, fptr_in;
   logic [CB-1:0]     idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic [1:0]        face_ff, face_in;
   logic              tet_op_ff, tet_op_in;
   mbf_pkg::vtx_type  v_ff [4];
   mbf_pkg::vtx_type  v_in [4];
   logic [KB-1:0]     hold_ff, hold_in;
   logic              hvalid_ff, hvalid_in;
   logic              hlast_ff, hlast_in;
   logic              rvalid_ff, rvalid_in;
   mbf_pkg::rsp_type  rdata_ff, rdata_in;

   logic              wr_key, wr_use;
   logic [IB-1:0]     wr_addr;
   logic [UB-1:0]     use_wr;
   logic [KB-1:0]     key_rd, ori_rd;
   logic [UB-1:0]     use_rd;

   mbf_pkg::vtx_type  fa, fb, fc, s0, s1, s2, t0, t1;
   logic [KB-1:0]     key, ori;

   // current face vertices and sorted key
   always_comb begin
      if (tet_op_ff) begin
         fa = v_ff[mbf_pkg::tri_pick(face_ff, 2'd0)];
         fb = v_ff[mbf_pkg::tri_pick(face_ff, 2'd1)];
         fc = v_ff[mbf_pkg::tri_pick(face_ff, 2'd2)];
         t0 = (fa > fb) ? fb : fa;
         t1 = (fa > fb) ? fa : fb;
         s2 = (t1 > fc) ? t1 : fc;
         t1 = (t1 > fc) ? fc : t1;
         s0 = (t0 > t1) ? t1 : t0;
         s1 = (t0 > t1) ? t0 : t1;
      end else begin
         fa = v_ff[mbf_pkg::edge_pick(face_ff, 1'b0)];
         fb = v_ff[mbf_pkg::edge_pick(face_ff, 1'b1)];
         fc = '0;
         t0 = '0;
         t1 = '0;
         s0 = (fa < fb) ? fa : fb;
         s1 = (fa < fb) ? fb : fa;
         s2 = '0;
      end
      key = {s2, s1, s0};
      ori = {fc, fb, fa};
   end

   // table memories
   mbf_ram #(.WIDTH(KB), .DEPTH(mbf_pkg::TABLE_DEPTH)) u_key_ram (
      .clock(clock), .wr_en(wr_key), .wr_addr(wr_addr), .wr_data(key),
      .rd_addr(idx_ff[IB-1:0]), .rd_data(key_rd));
   mbf_ram #(.WIDTH(KB), .DEPTH(mbf_pkg::TABLE_DEPTH)) u_ori_ram (
      .clock(clock), .wr_en(wr_key), .wr_addr(wr_addr), .wr_data(ori),
      .rd_addr(idx_ff[IB-1:0]), .rd_data(ori_rd));
   mbf_ram #(.WIDTH(UB), .DEPTH(mbf_pkg::TABLE_DEPTH)) u_use_ram (
      .clock(clock), .wr_en(wr_use), .wr_addr(wr_addr), .wr_data(use_wr),
      .rd_addr(idx_ff[IB-1:0]), .rd_data(use_rd));

   assign req_ch.ready = (state_ff == mbf_pkg::ST_IDLE);
   assign rsp_ch.valid = rvalid_ff;
   assign rsp_ch.data  = rdata_ff;

   // sequencer
   always_comb begin
      logic last_face_sel;
      last_face_sel = tet_op_ff ? (face_ff == 2'd3) : (face_ff == 2'd2);
      state_in  = state_ff;
      tetra_in  = csr_wr_en ? csr_wr_data : tetra_ff;
      total_in  = total_ff;
      fptr_in   = fptr_ff;
      idx_in    = idx_ff;
      ovf_in    = ovf_ff;
      face_in   = face_ff;
      tet_op_in = tet_op_ff;
      v_in      = v_ff;
      hold_in   = hold_ff;
      hvalid_in = hvalid_ff;
      hlast_in  = hlast_ff;
      rvalid_in = rvalid_ff && !rsp_ch.ready;
      rdata_in  = rdata_ff;
      wr_key    = 1'b0;
      wr_use    = 1'b0;
      wr_addr   = idx_ff[IB-1:0];
      use_wr    = UB'(1);

      unique case (state_ff)
         mbf_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               v_in[0]   = VB'(req_ch.data.vert0);
               v_in[1]   = VB'(req_ch.data.vert1);
               v_in[2]   = VB'(req_ch.data.vert2);
               v_in[3]   = VB'(req_ch.data.vert3);
               tet_op_in = tetra_ff;
               face_in   = 2'd0;
               priority if (req_ch.data.mode == mbf_pkg::MODE_INSERT) begin
                  idx_in   = '0;
                  state_in = mbf_pkg::ST_ICHK;
               end else if (req_ch.data.mode == mbf_pkg::MODE_FETCH) begin
                  idx_in   = fptr_ff;
                  state_in = mbf_pkg::ST_FCHK;
               end else if (req_ch.data.mode == mbf_pkg::MODE_CLEAR) begin
                  total_in = '0;
                  fptr_in  = '0;
                  ovf_in   = 1'b0;
               end else begin
                  // unused mode: request is dropped
                  state_in = mbf_pkg::ST_IDLE;
               end
            end
         end
         mbf_pkg::ST_ICHK: begin
            if (idx_ff >= total_ff) begin
               // key not present: append or flag overflow
               if (total_ff == FULL) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_key   = 1'b1;
                  wr_use   = 1'b1;
                  wr_addr  = total_ff[IB-1:0];
                  total_in = total_ff + CB'(1);
               end
               idx_in  = '0;
               face_in = face_ff + 2'd1;
               if (last_face_sel) state_in = mbf_pkg::ST_IDLE;
            end else begin
               state_in = mbf_pkg::ST_ICMP;
            end
         end
         mbf_pkg::ST_ICMP: begin
            if (key_rd == key) begin
               // known key: saturating use count
               wr_use  = 1'b1;
               use_wr  = (use_rd == UB'(2)) ? UB'(2) : use_rd + UB'(1);
               idx_in  = '0;
               face_in = face_ff + 2'd1;
               state_in = last_face_sel ? mbf_pkg::ST_IDLE : mbf_pkg::ST_ICHK;
            end else begin
               idx_in   = idx_ff + CB'(1);
               state_in = mbf_pkg::ST_ICHK;
            end
         end
         mbf_pkg::ST_FCHK: begin
            if (idx_ff >= total_ff) begin
               fptr_in   = total_ff;
               hold_in   = '0;
               hvalid_in = 1'b0;
               hlast_in  = 1'b1;
               state_in  = mbf_pkg::ST_OUT;
            end else begin
               state_in = mbf_pkg::ST_FCMP;
            end
         end
         mbf_pkg::ST_FCMP: begin
            idx_in = idx_ff + CB'(1);
            if (use_rd == UB'(1)) begin
               fptr_in   = idx_ff + CB'(1);
               hold_in   = ori_rd;
               hvalid_in = 1'b1;
               state_in  = mbf_pkg::ST_LCHK;
            end else begin
               state_in = mbf_pkg::ST_FCHK;
            end
         end
         mbf_pkg::ST_LCHK: begin
            if (idx_ff >= total_ff) begin
               hlast_in = 1'b1;
               state_in = mbf_pkg::ST_OUT;
            end else begin
               state_in = mbf_pkg::ST_LCMP;
            end
         end
         mbf_pkg::ST_LCMP: begin
            if (use_rd == UB'(1)) begin
               hlast_in = 1'b0;
               state_in = mbf_pkg::ST_OUT;
            end else begin
               idx_in   = idx_ff + CB'(1);
               state_in = mbf_pkg::ST_LCHK;
            end
         end
         mbf_pkg::ST_OUT: begin
            if (!rvalid_ff || rsp_ch.ready) begin
               rvalid_in               = 1'b1;
               rdata_in.face_a         = 16'(hold_ff[VB-1:0]);
               rdata_in.face_b         = 16'(hold_ff[2*VB-1:VB]);
               rdata_in.face_c         = 16'(hold_ff[3*VB-1:2*VB]);
               rdata_in.face_valid     = hvalid_ff;
               rdata_in.last_face      = hlast_ff;
               rdata_in.table_overflow = ovf_ff;
               state_in                = mbf_pkg::ST_IDLE;
            end
         end
         default: state_in = mbf_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mbf_pkg::ST_IDLE;
         tetra_ff  <= 1'b1;
         total_ff  <= '0;
         fptr_ff   <= '0;
         ovf_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tetra_ff  <= tetra_in;
         total_ff  <= total_in;
         fptr_ff   <= fptr_in;
         ovf_ff    <= ovf_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      face_ff   <= face_in;
      tet_op_ff <= tet_op_in;
      v_ff      <= v_in;
      hold_ff   <= hold_in;
      hvalid_ff <= hvalid_in;
      hlast_ff  <= hlast_in;
      rdata_ff  <= rdata_in;
   end

endmodule

@@ sv/mbf_checker.sv @@
module mbf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mbf_pkg::rsp_type rsp_data
);

   // stalled response stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response straight out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // empty fetch reports last with zero face
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.face_valid |->
         rsp_data.last_face && rsp_data.face_a == 16'd0 &&
         rsp_data.face_b == 16'd0 && rsp_data.face_c == 16'd0)
      else $error("empty fetch result malformed");

   // overflow flag never falls without a fresh response in between
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_overflow && !rsp_ready |=> rsp_data.table_overflow)
      else $error("overflow flag changed while stalled");

endmodule

bind mesh_boundary_face_extractor_unit mbf_checker u_mbf_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_data(rsp_ch.data)
);
